>>> hdl/fir_convolve_edge_truncated_assert.svh
// ---------------------------------------------------------------------------
// fir_convolve_edge_truncated_assert.svh
// assertion macros used by the checker file of the fir block
// ---------------------------------------------------------------------------
`ifndef FIR_CONVOLVE_EDGE_TRUNCATED_ASSERT_SVH
`define FIR_CONVOLVE_EDGE_TRUNCATED_ASSERT_SVH

// same-cycle implication, idle during reset
`define FCE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define FCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs while reset is high
`define FCE_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fce_pkg.sv
// ---------------------------------------------------------------------------
// fce_pkg
// constants, types and register codes of the centered fir filter
// ---------------------------------------------------------------------------
package fce_pkg;

  // default sizes
  localparam int MAX_TAPS_DEF    = 7;
  localparam int SAMPLE_BITS_DEF = 16;

  // coefficient registers
  localparam int NUM_TAPS  = 7;
  localparam int TAP_BITS  = 16;
  localparam int TAP_IDX_W = $clog2(NUM_TAPS);
  localparam int FRAC_BITS = 15;
  localparam int KW_BITS   = 3;
  localparam int SEEN_BITS = 3;

  // configuration channel
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [TAP_BITS-1:0] tap_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_TAP_COUNT = 4'd0;
  localparam cfg_idx_t REG_TAP_FIRST = 4'd1;
  localparam cfg_idx_t REG_TAP_LAST  = 4'd7;

  // reset values: 7 tap gaussian in q1.15
  localparam logic [KW_BITS-1:0] KW_RESET = 3'd7;
  localparam tap_t TAP_RESET [NUM_TAPS] = '{
    16'sd197, 16'sd2011, 16'sd8021, 16'sd12706, 16'sd8021, 16'sd2011, 16'sd197
  };

endpackage

>>> hdl/fce_channels.sv
// ---------------------------------------------------------------------------
// fce_channels
// valid/ready channels of the fir block: samples, results, configuration
// ---------------------------------------------------------------------------

// input samples
interface fce_in_if #(
  parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_sample;

  modport source (output valid, output sample_in, output last_sample, input ready);
  modport sink (input valid, input sample_in, input last_sample, output ready);
endinterface

// filtered results
interface fce_out_if #(
  parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          last_out;

  modport source (output valid, output sample_out, output last_out, input ready);
  modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

// register writes
interface fce_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fce_pkg::CFG_IDX_W-1:0]     index;
  logic [fce_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/fir_convolve_edge_truncated.sv
// ---------------------------------------------------------------------------
// fir_convolve_edge_truncated
// centered fir filter, up to seven q1.15 taps, zero outside the sequence
// ---------------------------------------------------------------------------
// usage:
//   samples carries one signed sample per request plus a last_sample flag.
//   results carries the filtered sample and last_out, set on the final
//   output of a sequence. cfg writes tap_count (index 0) and tap_0..tap_6
//   (indexes 1..7); cfg is ready outside reset. The user must write cfg only
//   while idle; the block itself does not enforce this.
// stages: a result is built in the product, sum and saturate stages in turn.
// throughput: one sample per cycle while results accepts. A last sample
//   flushes min(seen, h)+1 outputs, one per cycle while results accepts,
//   h = tap_count/2 (at most 3); samples is not ready during the replay.
// reset: taps go to the gaussian set, tap_count to 7, the window and the
//   sample count clear, the pipeline empties; samples and cfg are not ready
//   while rst is high.
// stall: each stage holds while the next one is full, so a waiting result
//   leaves room for up to two more in flight before samples drops ready.
// ---------------------------------------------------------------------------
module fir_convolve_edge_truncated #(
  parameter int MAX_TAPS    = fce_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  fce_in_if.sink    samples,
  fce_out_if.source results,
  fce_cfg_if.sink   cfg
);

  localparam int NUM_TAPS  = fce_pkg::NUM_TAPS;
  localparam int KW_BITS   = fce_pkg::KW_BITS;
  localparam int KW_CAP    = (MAX_TAPS < NUM_TAPS) ? MAX_TAPS : NUM_TAPS;
  localparam int H_MAX     = KW_CAP / 2;
  localparam int WIN_DEPTH = 2 * H_MAX + 1;
  localparam int PROD_W    = SAMPLE_BITS + fce_pkg::TAP_BITS;
  localparam int SUM_W     = PROD_W + $clog2(NUM_TAPS);
  localparam int SH_W      = SUM_W - fce_pkg::FRAC_BITS;
  localparam int WIDX_W    = KW_BITS + 2;

  localparam logic signed [SH_W-1:0] SAT_MAX =
    {{(SH_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // configuration registers
  logic [KW_BITS-1:0]       tap_count;
  fce_pkg::tap_t            taps [NUM_TAPS];
  fce_pkg::cfg_idx_t        tap_off;

  // sequence state
  smp_t                     window [WIN_DEPTH];
  smp_t                     window_next [WIN_DEPTH];
  smp_t                     win_new [WIN_DEPTH];
  smp_t                     issue_win [WIN_DEPTH];
  logic [fce_pkg::SEEN_BITS-1:0] seen, seen_next;
  logic                     flushing, flushing_next;
  logic [KW_BITS-1:0]       flush_d, flush_d_next;

  // derived control
  logic [KW_BITS-1:0]       kw_eff, h, start, issue_d;
  logic                     take, flush_go, issue_valid, issue_last;

  // pipeline
  logic                     s1_valid, s1_last, s1_adv;
  prod_t                    s1_prod [NUM_TAPS];
  prod_t                    prod_next [NUM_TAPS];
  logic                     s2_valid, s2_last, s2_adv;
  logic signed [SUM_W-1:0]  s2_sum, sum_next;
  logic                     out_valid, out_last, s3_ok;
  smp_t                     out_sample, sat_next;
  logic signed [SH_W-1:0]   shifted;

  // register writes
  assign cfg.ready = !rst;
  assign tap_off   = cfg.index - fce_pkg::REG_TAP_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= fce_pkg::KW_RESET;
      for (int i = 0; i < NUM_TAPS; i++) begin
        taps[i] <= fce_pkg::TAP_RESET[i];
      end
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == fce_pkg::REG_TAP_COUNT) begin
        tap_count <= cfg.data[KW_BITS-1:0];
      end else if (cfg.index >= fce_pkg::REG_TAP_FIRST &&
                   cfg.index <= fce_pkg::REG_TAP_LAST) begin
        taps[tap_off[fce_pkg::TAP_IDX_W-1:0]] <= cfg.data;
      end
    end
  end

  // effective width and half width
  always_comb begin
    if (tap_count == '0) begin
      kw_eff = KW_BITS'(1);
    end else if (int'(tap_count) > KW_CAP) begin
      kw_eff = KW_BITS'(KW_CAP);
    end else begin
      kw_eff = tap_count;
    end
    h     = kw_eff >> 1;
    start = (KW_BITS'(seen) < h) ? KW_BITS'(seen) : h;
  end

  // handshake chain, output register first
  assign s3_ok         = !out_valid || results.ready;
  assign s2_adv        = !s2_valid || s3_ok;
  assign s1_adv        = !s1_valid || s2_adv;
  assign samples.ready = s1_adv && !flushing && !rst;
  assign take          = samples.valid && samples.ready;
  assign flush_go      = flushing && s1_adv;

  // window with the new sample shifted in
  always_comb begin
    win_new[0] = samples.sample_in;
    for (int w = 1; w < WIN_DEPTH; w++) begin
      win_new[w] = window[w-1];
    end
  end

  // issue selection and sequence state update
  always_comb begin
    for (int w = 0; w < WIN_DEPTH; w++) begin
      issue_win[w]   = flushing ? window[w] : win_new[w];
      window_next[w] = window[w];
    end
    seen_next     = seen;
    flushing_next = flushing;
    flush_d_next  = flush_d;

    if (flushing) begin
      issue_d    = flush_d;
      issue_last = (flush_d == '0);
    end else begin
      issue_d    = samples.last_sample ? start : h;
      issue_last = samples.last_sample && (start == '0);
    end
    issue_valid = flush_go || (take && (samples.last_sample || KW_BITS'(seen) >= h));

    if (flush_go) begin
      if (flush_d == '0) begin
        // final flush output: start a fresh sequence
        for (int w = 0; w < WIN_DEPTH; w++) begin
          window_next[w] = '0;
        end
        seen_next     = '0;
        flushing_next = 1'b0;
      end else begin
        flush_d_next = flush_d - KW_BITS'(1);
      end
    end else if (take) begin
      if (samples.last_sample) begin
        seen_next = '0;
        if (start == '0) begin
          for (int w = 0; w < WIN_DEPTH; w++) begin
            window_next[w] = '0;
          end
        end else begin
          for (int w = 0; w < WIN_DEPTH; w++) begin
            window_next[w] = win_new[w];
          end
          flushing_next = 1'b1;
          flush_d_next  = start - KW_BITS'(1);
        end
      end else begin
        for (int w = 0; w < WIN_DEPTH; w++) begin
          window_next[w] = win_new[w];
        end
        if (seen != '1) begin
          seen_next = seen + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WIN_DEPTH; w++) begin
        window[w] <= '0;
      end
      seen     <= '0;
      flushing <= 1'b0;
      flush_d  <= '0;
    end else begin
      for (int w = 0; w < WIN_DEPTH; w++) begin
        window[w] <= window_next[w];
      end
      seen     <= seen_next;
      flushing <= flushing_next;
      flush_d  <= flush_d_next;
    end
  end

  // one product per tap lane; sample picked at index d + h - tap
  always_comb begin
    logic [WIDX_W-1:0] widx;
    smp_t              sel;
    for (int t = 0; t < NUM_TAPS; t++) begin
      widx = {2'b00, issue_d} + {2'b00, h} - WIDX_W'(t);
      sel  = '0;
      for (int w = 0; w < WIN_DEPTH; w++) begin
        if (widx == WIDX_W'(w)) begin
          sel = issue_win[w];
        end
      end
      if (KW_BITS'(t) < kw_eff) begin
        prod_next[t] = PROD_W'(sel) * PROD_W'(taps[t]);
      end else begin
        prod_next[t] = '0;
      end
    end
  end

  // sum of the products
  always_comb begin
    sum_next = '0;
    for (int t = 0; t < NUM_TAPS; t++) begin
      sum_next = sum_next + SUM_W'(s1_prod[t]);
    end
  end

  // floor shift and saturate
  always_comb begin
    shifted = SH_W'(s2_sum >>> fce_pkg::FRAC_BITS);
    if (shifted > SAT_MAX) begin
      sat_next = SAMPLE_BITS'(SAT_MAX);
    end else if (shifted < SAT_MIN) begin
      sat_next = SAMPLE_BITS'(SAT_MIN);
    end else begin
      sat_next = SAMPLE_BITS'(shifted);
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= issue_valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
      if (s3_ok) begin
        out_valid <= s2_valid;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (s1_adv && issue_valid) begin
      s1_last <= issue_last;
      for (int t = 0; t < NUM_TAPS; t++) begin
        s1_prod[t] <= prod_next[t];
      end
    end
    if (s2_adv && s1_valid) begin
      s2_last <= s1_last;
      s2_sum  <= sum_next;
    end
    if (s3_ok && s2_valid) begin
      out_last   <= s2_last;
      out_sample <= sat_next;
    end
  end

  assign results.valid      = out_valid;
  assign results.sample_out = out_sample;
  assign results.last_out   = out_last;

endmodule

>>> hdl/fce_checker.sv
// ---------------------------------------------------------------------------
// fce_checker
// port-level checks of the fir block, bound to fir_convolve_edge_truncated
// ---------------------------------------------------------------------------
`include "fir_convolve_edge_truncated_assert.svh"

module fce_checker #(
  parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_last,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_sample,
  input logic                   out_last,
  input logic                   cfg_ready
);

  // sequences whose final output is still owed
  logic [2:0] open_seqs;
  logic       seq_in, seq_out;

  assign seq_in  = in_valid && in_ready && in_last;
  assign seq_out = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_seqs <= '0;
    end else if (seq_in && !seq_out) begin
      open_seqs <= open_seqs + 3'd1;
    end else if (seq_out && !seq_in) begin
      open_seqs <= open_seqs - 3'd1;
    end
  end

  // reset empties the output register
  `FCE_ASSERT_RESET(a_reset_clears_out, rst, !out_valid, "result valid after reset")

  // a stalled result keeps its value
  `FCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(out_last), "stalled result changed")

  // at most three sequence ends in flight, never an end without a sequence
  `FCE_ASSERT_SAME(a_open_bound, 1'b1, open_seqs <= 3'd3, "too many unfinished sequences")

  // register writes are never refused
  `FCE_ASSERT_SAME(a_cfg_ready, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind fir_convolve_edge_truncated fce_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_fce_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .in_last    (samples.last_sample),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_sample (results.sample_out),
  .out_last   (results.last_out),
  .cfg_ready  (cfg.ready)
);
